>>> rtl/lbfgs_pkg.sv
// lbfgs_pkg: shared constants, types and helpers of the l-bfgs direction unit
// no dependencies

package lbfgs_pkg;

  localparam int HistDepth = 3;
  localparam int VecLen    = 64;
  localparam int IdxW      = $clog2(VecLen);
  localparam int CntW      = $clog2(VecLen + 1);
  localparam int SlotW     = (HistDepth > 1) ? $clog2(HistDepth) : 1;
  localparam int FillW     = $clog2(HistDepth + 1);
  localparam int HAddrW    = $clog2(HistDepth * VecLen);

  localparam logic signed [31:0] SatMax = 32'sh7fffffff;
  localparam logic signed [31:0] SatMin = 32'sh80000000;

  // divider request
  typedef struct packed {
    logic               start;
    logic signed [63:0] num;
    logic signed [63:0] den;
  } div_req_t;

  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    if (v > 66'sd2147483647) return SatMax;
    if (v < -66'sd2147483648) return SatMin;
    return v[31:0];
  endfunction

  // q16.16 product: exact 64 bit product, arithmetic shift is floor
  function automatic logic signed [47:0] mulq(input logic signed [31:0] a,
                                              input logic signed [31:0] b);
    logic signed [63:0] p;
    p = a * b;
    return p[63:16];
  endfunction

endpackage

>>> rtl/lbfgs_div.sv
// lbfgs_div: serial q16.16 divider, one quotient bit per cycle
// depends on lbfgs_pkg

module lbfgs_div (
  input  logic                     clk,
  input  logic                     rst_n,
  input  lbfgs_pkg::div_req_t      req,
  output logic                     done,
  output logic signed [31:0]       quo
);
  import lbfgs_pkg::*;

  // |num|*65536 / |den| restoring, 80 bit dividend, quotient clamped to 2^31
  logic [79:0] rem_r, rem_nxt;
  logic [79:0] dvd_r, dvd_nxt;
  logic [63:0] den_r, den_nxt;
  logic [79:0] q_r, q_nxt;
  logic [6:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic        neg_r, neg_nxt;
  logic        done_r, done_nxt;
  logic [80:0] trial;
  logic [63:0] un, ud;
  logic [79:0] qc;

  always_comb begin
    un = req.num[63] ? 64'(-req.num) : req.num;
    ud = req.den[63] ? 64'(-req.den) : req.den;
  end

  always_comb begin
    rem_nxt = rem_r; dvd_nxt = dvd_r; den_nxt = den_r; q_nxt = q_r;
    cnt_nxt = cnt_r; busy_nxt = busy_r; neg_nxt = neg_r; done_nxt = 1'b0;
    trial = {rem_r, dvd_r[79]} - {17'd0, den_r};
    if (req.start) begin
      rem_nxt = '0; dvd_nxt = {un, 16'd0}; den_nxt = ud; q_nxt = '0;
      cnt_nxt = 7'd80; busy_nxt = (ud != 64'd0);
      done_nxt = (ud == 64'd0);
      neg_nxt = (req.num[63] != req.den[63]) && (ud != 64'd0);
    end else if (busy_r) begin
      if (!trial[80]) begin
        rem_nxt = trial[79:0]; q_nxt = {q_r[78:0], 1'b1};
      end else begin
        rem_nxt = {rem_r[78:0], dvd_r[79]}; q_nxt = {q_r[78:0], 1'b0};
      end
      dvd_nxt = {dvd_r[78:0], 1'b0};
      cnt_nxt = cnt_r - 7'd1;
      if (cnt_r == 7'd1) begin
        busy_nxt = 1'b0; done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0; done_r <= 1'b0; cnt_r <= '0; q_r <= '0; neg_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt; done_r <= done_nxt; cnt_r <= cnt_nxt;
      q_r <= q_nxt; neg_r <= neg_nxt;
    end
    rem_r <= rem_nxt; dvd_r <= dvd_nxt; den_r <= den_nxt;
  end

  always_comb begin
    qc = (q_r >= 80'h80000000) ? 80'h80000000 : q_r;
    if (neg_r) quo = sat32(-$signed({2'b00, qc[63:0]}));
    else       quo = sat32($signed({2'b00, qc[63:0]}));
  end
  assign done = done_r;

endmodule

>>> rtl/lbfgs_direction_unit.sv
// lbfgs_direction_unit: l-bfgs two-loop recursion search direction
// depends on lbfgs_pkg and lbfgs_div
//
// channel | dir | payload
// in_     | in  | tdata {g_value, x_value}, tlast = last
// out_    | out | tdata dx_value, tuser {fallback}, tlast = last_res
//
// element requests are taken while in_tready is high; after the vector ends a
// sequencer runs multiply-accumulate passes over the vector and a serial
// divider; a first or degenerate vector skips the history passes and the
// divider. results leave one per cycle through an output register and hold on
// out_tready; in_tready stays low from the last element to the last result.
// reset is synchronous

module lbfgs_direction_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // x_value[31:0], g_value[63:32]
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // dx_value[31:0]
  output logic        out_tuser,  // fallback[0]
  output logic        out_tlast
);
  import lbfgs_pkg::*;

  localparam logic [3:0] StIn    = 4'd0;
  localparam logic [3:0] StSy    = 4'd1;  // form s, y, ys, yy, init work
  localparam logic [3:0] StChk   = 4'd2;
  localparam logic [3:0] StStore = 4'd3;  // copy s,y to slot
  localparam logic [3:0] StDot   = 4'd4;  // dot of history vector with work
  localparam logic [3:0] StDiv   = 4'd5;
  localparam logic [3:0] StAxpy  = 4'd6;
  localparam logic [3:0] StScl   = 4'd7;
  localparam logic [3:0] StOut   = 4'd8;

  // memories
  logic signed [31:0] s_mem [HistDepth*VecLen];
  logic signed [31:0] y_mem [HistDepth*VecLen];
  logic signed [31:0] x_mem [VecLen];
  logic signed [31:0] g_mem [VecLen];
  logic signed [31:0] px_mem [VecLen];
  logic signed [31:0] pg_mem [VecLen];
  logic signed [31:0] w_mem [VecLen];
  logic signed [31:0] ns_mem [VecLen];
  logic signed [31:0] ny_mem [VecLen];
  logic signed [63:0] ys_prod_r [HistDepth];
  logic signed [31:0] alpha_r [HistDepth];

  logic [3:0]       st_r;
  logic [CntW-1:0]  cnt_r, len_r;
  logic [CntW:0]    ptr_r;       // element pointer with one read-latency slot
  logic [SlotW-1:0] slot_r, j_r;
  logic [FillW-1:0] fill_r, k_r;
  logic             started_r, fb_r, loop2_r;
  logic signed [63:0] acc_r, acc2_r;
  logic signed [31:0] coef_r, scale_r;
  logic               phase_r;   // 0 = dot in loop, 1 = scale divider

  // registered reads
  logic signed [31:0] rx_r, rg_r, rpx_r, rpg_r, rw_r, rs_r, ry_r, rh_r;
  logic [IdxW-1:0]    ra_r;
  logic               rv_r;
  logic [IdxW-1:0]    ridx;
  logic [HAddrW-1:0]  haddr;

  div_req_t           dreq;
  logic               ddone;
  logic signed [31:0] dquo;

  lbfgs_div u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .done(ddone), .quo(dquo));

  logic               in_acc;
  logic signed [31:0] sv, yv, wn;
  logic [CntW-1:0]    lenm;

  assign in_tready = (st_r == StIn);
  assign in_acc    = in_tvalid && in_tready;
  assign ridx      = ptr_r[IdxW-1:0];
  assign haddr     = HAddrW'(j_r * VecLen) + HAddrW'(ridx);
  assign lenm      = len_r;

  always_ff @(posedge clk) begin
    if (in_acc) begin
      x_mem[cnt_r[IdxW-1:0]] <= in_tdata[31:0];
      g_mem[cnt_r[IdxW-1:0]] <= in_tdata[63:32];
    end
    rx_r <= x_mem[ridx]; rg_r <= g_mem[ridx];
    rpx_r <= px_mem[ridx]; rpg_r <= pg_mem[ridx];
    // a stalled result keeps its pending read
    if (st_r != StOut || !out_tvalid || out_tready) begin
      rw_r <= w_mem[ridx];
      ra_r <= ridx;
    end
    rs_r <= ns_mem[ridx]; ry_r <= ny_mem[ridx];
    rh_r <= (loop2_r ^ (st_r == StAxpy)) ? y_mem[haddr] : s_mem[haddr];
  end

  always_comb begin
    sv = sat32(66'($signed(rx_r)) - 66'($signed(rpx_r)));
    yv = sat32(66'($signed(rg_r)) - 66'($signed(rpg_r)));
  end

  // sequencer
  logic div_go_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= StIn; cnt_r <= '0; len_r <= '0; ptr_r <= '0; slot_r <= '0;
      fill_r <= '0; started_r <= 1'b0; fb_r <= 1'b0; rv_r <= 1'b0;
      j_r <= '0; k_r <= '0; loop2_r <= 1'b0; phase_r <= 1'b0;
      div_go_r <= 1'b0;
    end else begin
      div_go_r <= 1'b0;
      unique case (st_r)
        StIn: begin
          if (in_acc) begin
            if (in_tlast || cnt_r == CntW'(VecLen - 1)) begin
              len_r <= cnt_r + 1'b1; cnt_r <= '0; ptr_r <= '0; rv_r <= 1'b0;
              acc_r <= '0; acc2_r <= '0; fb_r <= 1'b0;
              st_r <= StSy;
            end else cnt_r <= cnt_r + 1'b1;
          end
        end
        StSy: begin
          // element ra_r is valid when rv_r
          if (ptr_r < (CntW+1)'(len_r)) ptr_r <= ptr_r + 1'b1;
          rv_r <= (ptr_r < (CntW+1)'(len_r));
          if (rv_r) begin
            w_mem[ra_r] <= sat32(-66'($signed(rg_r)));
            ns_mem[ra_r] <= sv; ny_mem[ra_r] <= yv;
            px_mem[ra_r] <= rx_r; pg_mem[ra_r] <= rg_r;
            acc_r <= acc_r + 64'(mulq(yv, sv));
            acc2_r <= acc2_r + 64'(mulq(yv, yv));
          end
          if (!rv_r && ptr_r == (CntW+1)'(len_r)) st_r <= StChk;
        end
        StChk: begin
          ptr_r <= '0; rv_r <= 1'b0;
          if (!started_r) begin
            started_r <= 1'b1; st_r <= StOut;
          end else if (acc_r == 64'sd0 || acc2_r == 64'sd0) begin
            fb_r <= 1'b1; st_r <= StOut;
          end else begin
            ys_prod_r[slot_r] <= acc_r;
            j_r <= slot_r; st_r <= StStore;
          end
        end
        StStore: begin
          if (ptr_r < (CntW+1)'(len_r)) ptr_r <= ptr_r + 1'b1;
          rv_r <= (ptr_r < (CntW+1)'(len_r));
          if (rv_r) begin
            s_mem[HAddrW'(j_r * VecLen) + HAddrW'(ra_r)] <= rs_r;
            y_mem[HAddrW'(j_r * VecLen) + HAddrW'(ra_r)] <= ry_r;
          end
          if (!rv_r && ptr_r == (CntW+1)'(len_r)) begin
            slot_r <= (slot_r == SlotW'(HistDepth - 1)) ? '0 : slot_r + 1'b1;
            if (fill_r < FillW'(HistDepth)) fill_r <= fill_r + 1'b1;
            // first loop starts at newest slot
            j_r <= slot_r; k_r <= '0; loop2_r <= 1'b0;
            ptr_r <= '0; acc_r <= '0; st_r <= StDot;
          end
        end
        StDot: begin
          if (ptr_r < (CntW+1)'(len_r)) ptr_r <= ptr_r + 1'b1;
          rv_r <= (ptr_r < (CntW+1)'(len_r));
          if (rv_r) acc_r <= acc_r + 64'(mulq(rh_r, rw_r));
          if (!rv_r && ptr_r == (CntW+1)'(len_r)) begin
            div_go_r <= 1'b1; phase_r <= 1'b0; st_r <= StDiv;
          end
        end
        StDiv: begin
          if (ddone) begin
            ptr_r <= '0; rv_r <= 1'b0;
            if (phase_r) begin
              scale_r <= dquo; st_r <= StScl;
            end else begin
              if (!loop2_r) begin
                alpha_r[j_r] <= dquo;
                coef_r <= sat32(-66'(dquo));
              end else
                coef_r <= sat32(66'(alpha_r[j_r]) - 66'(dquo));
              st_r <= StAxpy;
            end
          end
        end
        StAxpy: begin
          if (ptr_r < (CntW+1)'(len_r)) ptr_r <= ptr_r + 1'b1;
          rv_r <= (ptr_r < (CntW+1)'(len_r));
          if (rv_r) w_mem[ra_r] <= sat32(66'(rw_r) + 66'(mulq(coef_r, rh_r)));
          if (!rv_r && ptr_r == (CntW+1)'(len_r)) begin
            ptr_r <= '0; acc_r <= '0;
            if (!loop2_r) begin
              if (k_r + 1'b1 == fill_r) begin
                phase_r <= 1'b1; div_go_r <= 1'b1; st_r <= StDiv;
              end else begin
                k_r <= k_r + 1'b1;
                j_r <= (j_r == '0) ? SlotW'(HistDepth - 1) : j_r - 1'b1;
                st_r <= StDot;
              end
            end else begin
              if (k_r + 1'b1 == fill_r) st_r <= StOut;
              else begin
                k_r <= k_r + 1'b1;
                j_r <= (j_r == SlotW'(HistDepth - 1)) ? '0 : j_r + 1'b1;
                st_r <= StDot;
              end
            end
          end
        end
        StScl: begin
          if (ptr_r < (CntW+1)'(len_r)) ptr_r <= ptr_r + 1'b1;
          rv_r <= (ptr_r < (CntW+1)'(len_r));
          if (rv_r) w_mem[ra_r] <= sat32(66'(mulq(rw_r, scale_r)));
          if (!rv_r && ptr_r == (CntW+1)'(len_r)) begin
            ptr_r <= '0; acc_r <= '0; loop2_r <= 1'b1; k_r <= '0;
            st_r <= StDot;  // j_r already holds the oldest slot
          end
        end
        StOut: begin
          if (out_tvalid && out_tready && out_tlast) begin
            st_r <= StIn; ptr_r <= '0;
          end else if (!out_tvalid || out_tready) begin
            if (ptr_r < (CntW+1)'(len_r)) ptr_r <= ptr_r + 1'b1;
          end
        end
        default: st_r <= StIn;
      endcase
    end
  end

  // divider requests: ys is held in ys_prod_r, yy in acc2_r
  logic signed [63:0] dden;
  assign dden = phase_r ? acc2_r : ys_prod_r[j_r];

  // output register: the w read at the pointer lands in rw_r, then in od_r
  logic ov_r, olast_r, pend_r;
  logic [31:0] od_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0; pend_r <= 1'b0;
    end else begin
      if (st_r == StOut && (!out_tvalid || out_tready) && !(ov_r && olast_r)) begin
        pend_r <= (ptr_r < (CntW+1)'(len_r));
      end else if (!(st_r == StOut)) pend_r <= 1'b0;
      if (out_tvalid && out_tready) ov_r <= 1'b0;
      if (pend_r && (!ov_r || out_tready) && !(ov_r && olast_r)) begin
        ov_r <= 1'b1; od_r <= rw_r;
        olast_r <= ((CntW+1)'(ra_r) + 1'b1 == (CntW+1)'(lenm));
      end
    end
  end

  assign out_tvalid = ov_r;
  assign out_tdata  = od_r;
  assign out_tlast  = olast_r;
  assign out_tuser  = fb_r;

  // divider feed
  always_comb begin
    dreq.start = div_go_r;
    dreq.num   = phase_r ? ys_prod_r[slot_r == '0 ? SlotW'(HistDepth - 1) : slot_r - 1'b1]
                         : acc_r;
    dreq.den   = dden;
  end

  property p_ready_idle;
    @(posedge clk) disable iff (!rst_n) in_tready |-> !out_tvalid;
  endproperty
  a_ready_idle: assert property (p_ready_idle) else $error("input open while output busy");

  property p_fill;
    @(posedge clk) disable iff (!rst_n) fill_r <= FillW'(HistDepth);
  endproperty
  a_fill: assert property (p_fill) else $error("history fill overflow");

endmodule

>>> dv/lbfgs_direction_checker.sv
`timescale 1ns / 100ps
// checker for the l-bfgs direction unit: predicts the search direction per vector
// and compares each result request; depends on lbfgs_pkg for sizes

module lbfgs_direction_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [63:0] in_tdata,
  input  logic        in_tlast,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [31:0] out_tdata,
  input  logic        out_tuser,
  input  logic        out_tlast,
  output int          fail_count,
  output int          pending_count
);
  import lbfgs_pkg::*;

  typedef struct packed {
    logic signed [31:0] dx;
    logic               lst;
    logic               fb;
  } dir_elem_t;

  dir_elem_t dir_queue[$];

  logic signed [31:0] hist_s[HistDepth][VecLen];
  logic signed [31:0] hist_y[HistDepth][VecLen];
  logic signed [63:0] hist_ys[HistDepth];
  logic signed [31:0] hist_alpha[HistDepth];
  logic signed [31:0] last_x[VecLen];
  logic signed [31:0] last_g[VecLen];
  logic signed [31:0] dir_vec[VecLen];
  logic signed [31:0] col_x[VecLen];
  logic signed [31:0] col_g[VecLen];
  int unsigned next_slot, pairs_held, elem_idx;
  bit have_prev;

  assign pending_count = dir_queue.size();

  function automatic logic signed [31:0] clip32(input logic signed [127:0] v);
    if (v > 128'sd2147483647) return 32'sh7fffffff;
    if (v < -128'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  // q16.16 product, floor on the shift
  function automatic logic signed [63:0] qmul(input logic signed [31:0] a,
                                              input logic signed [31:0] b);
    logic signed [63:0] p;
    p = 64'(a) * 64'(b);
    return p >>> 16;
  endfunction

  function automatic logic signed [63:0] qdot(input logic signed [31:0] a[VecLen],
                                              input logic signed [31:0] b[VecLen],
                                              input int n);
    logic signed [63:0] acc;
    acc = 0;
    for (int i = 0; i < n; i++) acc += qmul(a[i], b[i]);
    return acc;
  endfunction

  // (num<<16)/den truncated toward zero, saturated
  function automatic logic signed [31:0] qdiv(input logic signed [63:0] num,
                                              input logic signed [63:0] den);
    logic signed [127:0] q;
    if (den == 0) return 0;
    q = (128'(num) <<< 16) / 128'(den);
    return clip32(q);
  endfunction

  function automatic void axpy_dir(input logic signed [31:0] coef,
                                   input logic signed [31:0] v[VecLen], input int n);
    for (int i = 0; i < n; i++)
      dir_vec[i] = clip32(128'(dir_vec[i]) + 128'(qmul(coef, v[i])));
  endfunction

  task automatic predict_direction(input int n);
    logic signed [31:0] ns[VecLen], ny[VecLen];
    logic signed [63:0] ys, yy;
    logic signed [31:0] scale, beta;
    int j, slot;
    bit fb;
    fb = 0;
    for (int i = 0; i < VecLen; i++) begin
      ns[i] = 0;
      ny[i] = 0;
    end
    for (int i = 0; i < n; i++) dir_vec[i] = clip32(-128'(col_g[i]));
    if (have_prev) begin
      for (int i = 0; i < n; i++) begin
        ns[i] = clip32(128'(col_x[i]) - 128'(last_x[i]));
        ny[i] = clip32(128'(col_g[i]) - 128'(last_g[i]));
      end
      ys = qdot(ny, ns, n);
      yy = qdot(ny, ny, n);
      if (ys == 0 || yy == 0) begin
        fb = 1;  // degenerate curvature: keep -g, history untouched
      end else begin
        slot = next_slot;
        for (int i = 0; i < n; i++) begin
          hist_s[slot][i] = ns[i];
          hist_y[slot][i] = ny[i];
        end
        hist_ys[slot] = ys;
        next_slot = (slot + 1) % HistDepth;
        if (pairs_held < HistDepth) pairs_held++;
        j = next_slot;
        for (int k = 0; k < pairs_held; k++) begin
          j = (j + HistDepth - 1) % HistDepth;
          hist_alpha[j] = qdiv(qdot(hist_s[j], dir_vec, n), hist_ys[j]);
          axpy_dir(clip32(-128'(hist_alpha[j])), hist_y[j], n);
        end
        scale = qdiv(ys, yy);
        for (int i = 0; i < n; i++) dir_vec[i] = clip32(128'(qmul(dir_vec[i], scale)));
        for (int k = 0; k < pairs_held; k++) begin
          beta = qdiv(qdot(hist_y[j], dir_vec, n), hist_ys[j]);
          axpy_dir(clip32(128'(hist_alpha[j]) - 128'(beta)), hist_s[j], n);
          j = (j + 1) % HistDepth;
        end
      end
    end
    for (int i = 0; i < n; i++) begin
      last_x[i] = col_x[i];
      last_g[i] = col_g[i];
    end
    have_prev = 1;
    for (int i = 0; i < n; i++) dir_queue.push_back('{dir_vec[i], i == n - 1, fb});
  endtask

  always @(posedge clk) begin
    dir_elem_t e;
    if (!rst_n) begin
      next_slot = 0;
      pairs_held = 0;
      elem_idx = 0;
      have_prev = 0;
      fail_count = 0;
      dir_queue.delete();
    end else begin
      // result side first: expectations from this edge cannot be due yet
      if (out_tvalid && out_tready) begin
        if (dir_queue.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) $display("unexpected result dx=%h", out_tdata);
        end else begin
          e = dir_queue.pop_front();
          if (out_tdata !== e.dx || out_tlast !== e.lst || out_tuser !== e.fb) begin
            fail_count++;
            if (fail_count <= 10)
              $display("mismatch: exp dx=%h last=%b fb=%b got dx=%h last=%b fb=%b",
                       e.dx, e.lst, e.fb, out_tdata, out_tlast, out_tuser);
          end
        end
      end
      if (in_tvalid && in_tready) begin
        col_x[elem_idx] = in_tdata[31:0];
        col_g[elem_idx] = in_tdata[63:32];
        elem_idx++;
        if (in_tlast || elem_idx == VecLen) begin
          predict_direction(elem_idx);
          elem_idx = 0;
        end
      end
    end
  end
endmodule

>>> dv/tb_lbfgs_direction_unit.sv
`timescale 1ns / 100ps
// testbench top for lbfgs_direction_unit: drives vector requests and
// back-pressure; depends on lbfgs_pkg, the unit and lbfgs_direction_checker

module tb_lbfgs_direction_unit;
  import lbfgs_pkg::*;

  logic        clk = 0;
  logic        rst_n = 0;
  logic        in_tvalid = 0;
  logic        in_tready;
  logic [63:0] in_tdata = '0;
  logic        in_tlast = 0;
  logic        out_tvalid;
  logic        out_tready = 0;
  logic [31:0] out_tdata;
  logic        out_tuser;
  logic        out_tlast;
  int          fail_count;
  int          pending_count;

  // idle percentages, changed per phase
  int unsigned send_idle = 0;
  int unsigned recv_stall = 0;
  bit          hold_off = 0;     // long receiver hold-off
  int          quiet_cycles = 0;
  // only the first vector is full length, later ones share one shorter length,
  // so no never-written entry is read
  int          vlen;

  always #5 clk = ~clk;

  lbfgs_direction_unit uut (.*);

  lbfgs_direction_checker chk (.*);

  // receiver: random stalls, or a forced hold-off
  always @(posedge clk) begin
    if (!rst_n) out_tready <= 0;
    else if (hold_off) out_tready <= 0;
    else out_tready <= ($urandom_range(99) >= recv_stall);
  end

  // watchdog on cycles with no accepted request
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > 200000) begin
      $display("status: fail");
      $finish;
    end
  end

  // one element request; sender idles at random first
  task automatic send_elem(input logic [31:0] x, input logic [31:0] g, input bit lst);
    while ($urandom_range(99) < send_idle) begin
      in_tvalid <= 0;
      @(posedge clk);
    end
    in_tvalid <= 1;
    in_tdata <= {g, x};
    in_tlast <= lst;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_val(input int mode);
    case (mode)
      0: return $urandom();
      1: return 32'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
      default: return $urandom_range(0, 3) == 0 ? 32'h7fffffff : 32'h80000000;
    endcase
  endfunction

  // whole vector; kind 0 random, 1 repeat previous (degenerate), 2 extremes
  logic [31:0] prev_x[VecLen], prev_g[VecLen];
  task automatic send_vector(input int kind, input int len, input bit use_long);
    logic [31:0] x, g;
    int mode;
    mode = $urandom_range(0, 1);
    for (int i = 0; i < len; i++) begin
      if (kind == 1) begin
        x = prev_x[i];
        g = prev_g[i];
      end else if (kind == 2) begin
        x = rand_val(2);
        g = rand_val(2);
      end else begin
        x = rand_val(mode);
        g = rand_val(mode);
      end
      prev_x[i] = x;
      prev_g[i] = g;
      // overlong: no tlast, the full-length element closes the vector
      send_elem(x, g, use_long ? 1'b0 : (i == len - 1));
    end
    in_tvalid <= 0;
  endtask

  task automatic drain;
    while (pending_count != 0) @(posedge clk);
    repeat (50) @(posedge clk);
  endtask

  initial begin
    int done_items;
    vlen = $urandom_range(2, 16);
    repeat (6) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed: full-length first vector closed by its count, degenerate
    // repeat, extremes, normal curvature
    send_vector(2, VecLen, 1);
    send_vector(1, vlen, 0);
    send_vector(2, vlen, 0);
    send_vector(0, vlen, 0);
    drain();

    // random phases with different idling
    done_items = VecLen + 3 * vlen;
    for (int ph = 0; ph < 4; ph++) begin
      send_idle  = (ph == 1 || ph == 3) ? (ph == 1 ? 57 : 29) : 0;
      recv_stall = (ph == 2 || ph == 3) ? (ph == 2 ? 57 : 29) : 0;
      do begin
        send_vector(($urandom_range(0, 7) == 0) ? 1 : 0, vlen, 0);
        done_items += vlen;
      end while (done_items < 100 + 53 * ph);
      if (ph == 1) begin
        // long receiver hold-off while the sender keeps offering
        hold_off = 1;
        fork
          begin
            repeat (3000) @(posedge clk);
            hold_off = 0;
          end
          begin
            send_vector(0, vlen, 0);
            send_vector(0, vlen, 0);
          end
        join
        done_items += 2 * vlen;
      end
      drain();  // sender waits for every result
    end

    drain();
    if (fail_count == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end
endmodule

>>> lbfgs_direction_unit.f
rtl/lbfgs_pkg.sv
rtl/lbfgs_div.sv
rtl/lbfgs_direction_unit.sv
dv/lbfgs_direction_checker.sv
dv/tb_lbfgs_direction_unit.sv
